[hw/rtl/sbw_pkg.sv]
// Package for the split read breakpoint window block.
// Holds the request and result structs, the anchor stage struct and the codes.
// No dependencies.
`default_nettype none

package sbw_pkg;

    localparam int unsigned POS_W = 31;
    localparam int unsigned WIN_W = 32;

    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    localparam logic [1:0] CLS_DEL  = 2'd0;
    localparam logic [1:0] CLS_DUP  = 2'd1;
    localparam logic [1:0] CLS_INVM = 2'd2;
    localparam logic [1:0] CLS_INVP = 2'd3;

    localparam logic [0:0] REG_HALF_WIDTH  = 1'd0;
    localparam logic [0:0] REG_MIN_QUALITY = 1'd1;

    localparam logic [15:0] HALF_WIDTH_RESET  = 16'd500;
    localparam logic [7:0]  MIN_QUALITY_RESET = 8'd0;

    typedef struct packed {
        logic [15:0]      a_ref;
        logic [POS_W-1:0] a_start;
        logic [POS_W-1:0] a_end;
        logic             a_reverse;
        logic [15:0]      a_query_start;
        logic [7:0]       a_quality;
        logic [15:0]      b_ref;
        logic [POS_W-1:0] b_start;
        logic [POS_W-1:0] b_end;
        logic             b_reverse;
        logic [15:0]      b_query_start;
        logic [7:0]       b_quality;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       breakpoint_class;
        logic [WIN_W-1:0] left_start;
        logic [WIN_W-1:0] left_end;
        logic [WIN_W-1:0] left_start_clip;
        logic [WIN_W-1:0] left_end_clip;
        logic [WIN_W-1:0] right_start;
        logic [WIN_W-1:0] right_end;
        logic [WIN_W-1:0] right_start_clip;
        logic [WIN_W-1:0] right_end_clip;
    } t_result;

    typedef struct packed {
        logic             vld;
        logic [1:0]       status;
        logic [1:0]       cls;
        logic             same;
        logic [POS_W-1:0] pl;
        logic [POS_W-1:0] pr;
        logic [POS_W-1:0] l_end;
        logic [POS_W-1:0] r_start;
    } t_anchor;

endpackage

`default_nettype wire

[hw/rtl/sbw_classify.sv]
// Ordering, classification and sanity stage of the breakpoint window block.
// Registers the anchors of one request. Depends on sbw_pkg.
`default_nettype none

module sbw_classify (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_vld,
    input  sbw_pkg::t_req    i_req,
    input  wire  [7:0]       i_min_quality,
    output sbw_pkg::t_anchor o_anchor
);

    sbw_pkg::t_anchor r_anchor;
    sbw_pkg::t_anchor n_anchor;

    logic                     swap;
    logic                     same;
    logic                     inv;
    logic                     order_ok;
    logic                     qual_low;
    logic                     qlt;
    logic                     qeq;
    logic                     l_rev;
    logic [sbw_pkg::POS_W-1:0] l_start, l_end, r_start, r_end;
    logic [1:0]               status;
    logic [1:0]               cls;

    always_comb begin
        swap = (i_req.a_ref > i_req.b_ref) ||
               ((i_req.a_ref == i_req.b_ref) && (i_req.a_start > i_req.b_start));
        same = (i_req.a_ref == i_req.b_ref);
        inv  = (i_req.a_reverse != i_req.b_reverse);
        qeq  = (i_req.a_query_start == i_req.b_query_start);
        if (swap) begin
            l_start  = i_req.b_start;
            l_end    = i_req.b_end;
            r_start  = i_req.a_start;
            r_end    = i_req.a_end;
            l_rev    = i_req.b_reverse;
            qlt      = (i_req.b_query_start < i_req.a_query_start);
            order_ok = (i_req.b_end < i_req.a_start);
        end else begin
            l_start  = i_req.a_start;
            l_end    = i_req.a_end;
            r_start  = i_req.b_start;
            r_end    = i_req.b_end;
            l_rev    = i_req.a_reverse;
            qlt      = (i_req.a_query_start < i_req.b_query_start);
            order_ok = (i_req.a_end < i_req.b_start);
        end
        qual_low = (i_req.a_quality < i_min_quality) || (i_req.b_quality < i_min_quality);

        if (!inv && qeq) begin
            status = sbw_pkg::ST_UNKNOWN;
        end else if (qual_low || (same && !order_ok)) begin
            status = sbw_pkg::ST_REJECTED;
        end else if (qeq) begin
            status = sbw_pkg::ST_UNKNOWN;
        end else begin
            status = sbw_pkg::ST_VALID;
        end

        if (!inv) begin
            cls = (qlt != l_rev) ? sbw_pkg::CLS_DEL : sbw_pkg::CLS_DUP;
        end else begin
            cls = (qlt == l_rev) ? sbw_pkg::CLS_INVM : sbw_pkg::CLS_INVP;
        end

        n_anchor.vld     = i_vld;
        n_anchor.status  = status;
        n_anchor.cls     = cls;
        n_anchor.same    = same;
        n_anchor.l_end   = l_end;
        n_anchor.r_start = r_start;
        case (cls)
            sbw_pkg::CLS_DEL: begin
                n_anchor.pl = l_end;
                n_anchor.pr = r_start;
            end
            sbw_pkg::CLS_DUP: begin
                n_anchor.pl = l_start;
                n_anchor.pr = r_end;
            end
            sbw_pkg::CLS_INVM: begin
                n_anchor.pl = l_start;
                n_anchor.pr = r_start;
            end
            default: begin
                n_anchor.pl = l_end;
                n_anchor.pr = r_end;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor <= '0;
        end else begin
            r_anchor <= n_anchor;
        end
    end

    assign o_anchor = r_anchor;

endmodule

`default_nettype wire

[hw/rtl/sbw_window.sv]
// Window stages of the breakpoint window block: clamped windows around the
// anchors, then overlap trim and the result register. Depends on sbw_pkg.
`default_nettype none

module sbw_window (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sbw_pkg::t_anchor i_anchor,
    input  wire  [15:0]      i_half_width,
    output logic             o_done,
    output sbw_pkg::t_result o_result
);

    localparam int unsigned W = sbw_pkg::WIN_W;

    logic                      r_vld;
    logic [1:0]                r_status;
    logic [1:0]                r_cls;
    logic                      r_same;
    logic [sbw_pkg::POS_W-1:0] r_l_end;
    logic [sbw_pkg::POS_W-1:0] r_r_start;
    logic [W-1:0]              r_ls, r_le, r_lsc, r_rs, r_re, r_rsc;
    logic [W-1:0]              n_ls, n_le, n_lsc, n_rs, n_re, n_rsc;

    logic                      r_done;
    sbw_pkg::t_result          r_result;
    sbw_pkg::t_result          n_result;

    logic [W-1:0] pl_w, pr_w, bd_w;
    logic [W-1:0] l_end_w, r_start_w;
    logic         trim_l, trim_r;

    always_comb begin
        pl_w  = {1'b0, i_anchor.pl};
        pr_w  = {1'b0, i_anchor.pr};
        bd_w  = {16'd0, i_half_width};
        n_le  = pl_w + bd_w;
        n_re  = pr_w + bd_w;
        if (pl_w > bd_w) begin
            n_ls  = pl_w - bd_w;
            n_lsc = '0;
        end else begin
            n_ls  = '0;
            n_lsc = pl_w;
        end
        if (pr_w > bd_w) begin
            n_rs  = pr_w - bd_w;
            n_rsc = '0;
        end else begin
            n_rs  = '0;
            n_rsc = pr_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= i_anchor.status;
        r_cls     <= i_anchor.cls;
        r_same    <= i_anchor.same;
        r_l_end   <= i_anchor.l_end;
        r_r_start <= i_anchor.r_start;
        r_ls      <= n_ls;
        r_le      <= n_le;
        r_lsc     <= n_lsc;
        r_rs      <= n_rs;
        r_re      <= n_re;
        r_rsc     <= n_rsc;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_anchor.vld;
        end
    end

    always_comb begin
        l_end_w   = {1'b0, r_l_end};
        r_start_w = {1'b0, r_r_start};
        trim_l    = r_same && (r_le >= r_start_w);
        trim_r    = r_same && (r_rs <= l_end_w);

        n_result                  = '0;
        n_result.status           = r_status;
        if (r_status == sbw_pkg::ST_VALID) begin
            n_result.breakpoint_class = r_cls;
            n_result.left_start       = r_ls;
            n_result.left_start_clip  = r_lsc;
            n_result.right_end        = r_re;
            if (trim_l) begin
                n_result.left_end_clip = r_le - r_start_w + W'(1);
                n_result.left_end      = r_start_w - W'(1);
            end else begin
                n_result.left_end_clip = '0;
                n_result.left_end      = r_le;
            end
            if (trim_r) begin
                n_result.right_start_clip = l_end_w - r_rs + W'(1);
                n_result.right_start      = l_end_w + W'(1);
            end else begin
                n_result.right_start_clip = r_rsc;
                n_result.right_start      = r_rs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hw/rtl/split_read_breakpoint_windows.sv]
// Top level of the split read breakpoint window block: request register,
// configuration registers and the two processing modules. Depends on sbw_pkg,
// sbw_classify and sbw_window.
//
// Usage: a request (both alignments of one split read) is taken at a rising
// clock edge where start is high and busy is low. busy is never raised, so a
// new request can be issued in every cycle; throughput is one request per
// clock. Each request gives exactly one result, shown on o_result with o_done
// high after the request has passed the request register,
// the classification stage and the window stage and the trim logic has fed
// the result register. Results leave in request order. The receiver cannot
// stall and must take each result when o_done is high.
// The APB-style port holds the window half width at address 0 and min_quality
// at address 4; pready is always high and a read returns the register value.
// Configuration must be written only when no request is in flight; unenforced.
// A synchronous active-low reset empties the pipeline and sets the window
// half width to 500 and min_quality to 0.
`default_nettype none

module split_read_breakpoint_windows (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  sbw_pkg::t_req    i_req,
    output logic             o_done,
    output sbw_pkg::t_result o_result,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [2:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]      r_half_width;
    logic [7:0]       r_min_quality;
    logic             r_req_vld;
    sbw_pkg::t_req    r_req;
    sbw_pkg::t_anchor anchor;
    logic             wr_en;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= sbw_pkg::HALF_WIDTH_RESET;
            r_min_quality <= sbw_pkg::MIN_QUALITY_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                sbw_pkg::REG_HALF_WIDTH:  r_half_width  <= pwdata[15:0];
                sbw_pkg::REG_MIN_QUALITY: r_min_quality <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sbw_pkg::REG_HALF_WIDTH:  prdata = {16'd0, r_half_width};
            sbw_pkg::REG_MIN_QUALITY: prdata = {24'd0, r_min_quality};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    sbw_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_req_vld),
        .i_req         (r_req),
        .i_min_quality (r_min_quality),
        .o_anchor      (anchor)
    );

    sbw_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_anchor     (anchor),
        .i_half_width (r_half_width),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire
